// ===== design/dts_pkg.sv =====
// Package for the depth-first topological sort block.
// Shared sizes and the vertex type; no dependencies.
package dts_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;
    localparam int VW = 6;
    localparam int CW = 7;

    typedef logic [VW-1:0] t_vtx;
endpackage

// ===== design/dts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/dfs_topological_sort_top.sv =====
// Top level of the depth-first topological sort: edge load, search sequencer, output.
// Uses dts_pkg and dts_ram (edge store, search stack, finish order).
//
//  channel | direction | handshake      | payload
//  cfg     | in        | valid / ready  | vertex_count
//  in      | in        | valid / stall  | action, edge_source, edge_target
//  out     | out       | valid / stall  | vertex, last, impossible, edge_dropped
//
// Edge loads can follow back to back. A run tries each root in S_ROOT, scans
// each edge of a visited vertex in S_RDE and S_EDGE, finishes a vertex in S_RDE and
// reloads its parent in S_RDTOP, S_TOP (registered reads); results pass S_RDF, S_EMIT.
// Marks clear on the cycle a run is accepted; no clearing pass after reset.
// A stalled output holds; input and config are stalled while a run is in progress.
module dfs_topological_sort_top #(
    parameter int MAX_VERTICES = dts_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = dts_pkg::MAX_EDGES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [dts_pkg::CW-1:0] i_vertex_count,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_action,
    input  logic [dts_pkg::VW-1:0] i_edge_source,
    input  logic [dts_pkg::VW-1:0] i_edge_target,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [dts_pkg::VW-1:0] o_vertex,
    output logic                   o_last,
    output logic                   o_impossible,
    output logic                   o_edge_dropped
);
    import dts_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int SW  = VW + ECW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ROOT  = 9'b000000010,
        S_RDTOP = 9'b000000100,
        S_TOP   = 9'b000001000,
        S_RDE   = 9'b000010000,
        S_EDGE  = 9'b000100000,
        S_RDF   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state r_state;
    logic [CW-1:0]  r_vcount;
    logic [ECW-1:0] r_ecount;
    logic           r_dropped;
    logic [MAX_VERTICES-1:0] r_visited, r_onpath;
    logic [VCW-1:0] r_root;
    logic [VCW-1:0] r_sp;
    logic [VW-1:0]  r_v;
    logic [ECW-1:0] r_p;
    logic [VCW-1:0] r_fin;
    logic           r_ovalid, r_olast, r_oimp, r_odrop;
    logic [VW-1:0]  r_overt;

    logic [VCW-1:0] w_n;
    always_comb begin
        if (r_vcount == '0) w_n = VCW'(1);
        else if (32'(r_vcount) > MAX_VERTICES) w_n = VCW'(MAX_VERTICES);
        else w_n = VCW'(r_vcount);
    end

    // edge store
    logic             e_we;
    logic [EAW-1:0]   e_waddr, e_raddr;
    logic [2*VW-1:0]  e_rdata;
    dts_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr),
        .i_wdata({i_edge_source, i_edge_target}), .i_raddr(e_raddr), .o_rdata(e_rdata)
    );
    // search stack: vertex and next edge position
    logic           s_we;
    logic [VAW-1:0] s_waddr, s_raddr;
    logic [SW-1:0]  s_wdata, s_rdata;
    dts_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );
    // finish order
    logic           f_we;
    logic [VAW-1:0] f_waddr, f_raddr;
    logic [VW-1:0]  f_rdata;
    dts_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fin (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(r_v),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    logic acc_in, out_free, w_cycle, w_hit, w_push, w_load;
    logic [VW-1:0] e_src, e_dst;
    assign e_src  = e_rdata[2*VW-1:VW];
    assign e_dst  = e_rdata[VW-1:0];
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign acc_in   = i_valid && !o_stall;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_cycle = r_visited[e_dst[VAW-1:0]] && r_onpath[e_dst[VAW-1:0]];
    assign w_hit   = (e_src == r_v);
    assign w_push  = w_hit && !r_visited[e_dst[VAW-1:0]] && (r_sp < VCW'(MAX_VERTICES));
    assign w_load  = out_free && ((r_state == S_EMIT) || (r_state == S_DONE));

    logic w_edge_ok;
    assign w_edge_ok = (32'(i_edge_source) < 32'(w_n)) && (32'(i_edge_target) < 32'(w_n))
                       && (32'(r_ecount) < MAX_EDGES);
    assign e_we    = acc_in && !i_action && w_edge_ok;
    assign e_waddr = r_ecount[EAW-1:0];
    assign e_raddr = r_p[EAW-1:0];
    assign s_raddr = VAW'(r_sp - VCW'(1));
    assign f_raddr = VAW'(r_fin - VCW'(1));
    assign f_waddr = r_fin[VAW-1:0];

    // parent saved with its next edge position when a child is pushed
    assign s_we    = (r_state == S_EDGE) && w_push;
    assign s_waddr = VAW'(r_sp - VCW'(1));
    assign s_wdata = {r_v, ECW'(r_p + ECW'(1))};
    assign f_we    = (r_state == S_RDE) && (r_p >= r_ecount) && (32'(r_fin) < MAX_VERTICES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_vcount <= CW'(1); r_ecount <= '0; r_dropped <= 1'b0;
            r_visited <= '0; r_onpath <= '0;
            r_sp <= '0; r_fin <= '0; r_root <= '0; r_p <= '0; r_v <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_vcount <= i_vertex_count;
            unique case (r_state)
                S_IDLE: if (acc_in) begin
                    if (i_action) begin
                        r_root <= '0; r_fin <= '0; r_sp <= '0;
                        r_visited <= '0; r_onpath <= '0;
                        r_state <= S_ROOT;
                    end else if (w_edge_ok) r_ecount <= r_ecount + ECW'(1);
                    else r_dropped <= 1'b1;
                end
                S_ROOT: begin
                    if (r_root >= w_n) begin
                        r_state <= S_RDF;
                    end else if (r_visited[r_root[VAW-1:0]]) begin
                        r_root <= r_root + VCW'(1);
                    end else begin
                        r_visited[r_root[VAW-1:0]] <= 1'b1;
                        r_onpath[r_root[VAW-1:0]]  <= 1'b1;
                        r_v <= VW'(r_root); r_p <= '0; r_sp <= VCW'(1);
                        r_state <= S_RDE;
                    end
                end
                S_RDTOP: r_state <= S_TOP;
                S_TOP: begin
                    r_v <= s_rdata[SW-1:ECW]; r_p <= s_rdata[ECW-1:0];
                    r_state <= S_RDE;
                end
                S_RDE: begin
                    if (r_p >= r_ecount) begin
                        r_onpath[r_v[VAW-1:0]] <= 1'b0;
                        if (32'(r_fin) < MAX_VERTICES) r_fin <= r_fin + VCW'(1);
                        r_sp <= r_sp - VCW'(1);
                        if (r_sp == VCW'(1)) begin
                            r_root <= r_root + VCW'(1); r_state <= S_ROOT;
                        end else r_state <= S_RDTOP;
                    end else r_state <= S_EDGE;
                end
                S_EDGE: begin
                    if (w_push) begin
                        r_visited[e_dst[VAW-1:0]] <= 1'b1;
                        r_onpath[e_dst[VAW-1:0]]  <= 1'b1;
                        r_v <= e_dst; r_p <= '0; r_sp <= r_sp + VCW'(1);
                        r_state <= S_RDE;
                    end else if (w_hit && w_cycle) begin
                        r_state <= S_DONE;
                    end else begin
                        r_p <= r_p + ECW'(1);
                        r_state <= S_RDE;
                    end
                end
                S_RDF: r_state <= S_EMIT;
                S_EMIT: if (out_free) begin
                    r_fin <= r_fin - VCW'(1);
                    if (r_fin == VCW'(1)) begin
                        r_ecount <= '0; r_dropped <= 1'b0; r_state <= S_IDLE;
                    end else r_state <= S_RDF;
                end
                S_DONE: if (out_free) begin
                    r_ecount <= '0; r_dropped <= 1'b0; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0; r_overt <= '0; r_olast <= 1'b0; r_oimp <= 1'b0;
            r_odrop <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
            r_overt  <= (r_state == S_EMIT) ? f_rdata : '0;
            r_olast  <= (r_state == S_DONE) || (r_fin == VCW'(1));
            r_oimp   <= (r_state == S_DONE);
            r_odrop  <= r_dropped;
        end else if (out_free) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_vertex = r_overt;
    assign o_last = r_olast;
    assign o_impossible = r_oimp;
    assign o_edge_dropped = r_odrop;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input taken during run");
    a_imp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_impossible) |-> o_last) else $error("impossible without last");
    a_onpath_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_onpath & ~r_visited) == '0)) else $error("on-path vertex not visited");
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_sp) <= MAX_VERTICES)) else $error("stack overflow");
endmodule
